// ===== design/bfic_pkg.sv =====
// Shared constants, command codes and types for the Bloom filter block.
// Used by every module under design/; depends on nothing else.
package bfic_pkg;

  localparam int MAX_BITS    = 1024;
  localparam int MAX_HASHES  = 16;

  localparam int KEY_W          = 32;
  localparam int CMD_W          = 2;
  localparam int NUM_HASHES_W   = 5;
  localparam int BIT_COUNT_W    = 11;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 16;

  localparam int HASH_MUL  = 53;
  localparam int SEED_MUL  = 47;
  localparam int MUL_W     = 6;
  localparam int SEED_W    = 6;
  localparam int PROD_W    = KEY_W + MUL_W;

  localparam int WORD_W      = 32;
  localparam int STORE_WORDS = MAX_BITS / WORD_W;
  localparam int WIDX_W      = $clog2(STORE_WORDS);
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int POS_W       = $clog2(MAX_BITS);
  localparam int NB_W        = POS_W + 1;
  localparam int K_W         = $clog2(MAX_HASHES + 1);
  localparam int DIV_STEPS   = PROD_W / 2;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_COUNT  = 4'd1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_CHECK,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PROBE,
    ST_DONE
  } back_state_e;

  typedef struct packed {
    op_e               op;
    logic [PROD_W-1:0] prod;
  } item_t;

  typedef struct packed {
    logic [K_W-1:0]  hashes;
    logic [NB_W-1:0] nbits;
  } cfg_t;

endpackage

// ===== design/bfic_front.sv =====
// Front end: takes input words, decodes the command and forms 53*key.
// Depends on bfic_pkg; feeds bfic_queue.
module bfic_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bfic_pkg::CMD_W-1:0]   cmd_i,
  input  logic [bfic_pkg::KEY_W-1:0]   key_i,
  input  logic                         q_full_i,
  output logic                         push_o,
  output bfic_pkg::item_t              item_o
);

  bfic_pkg::op_e op;

  always_comb begin
    unique case (cmd_i)
      bfic_pkg::CMD_INSERT: op = bfic_pkg::OP_INSERT;
      bfic_pkg::CMD_CHECK:  op = bfic_pkg::OP_CHECK;
      bfic_pkg::CMD_CLEAR:  op = bfic_pkg::OP_CLEAR;
      default:              op = bfic_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = !q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign item_o.op   = op;
  assign item_o.prod = bfic_pkg::PROD_W'(key_i) *
                       bfic_pkg::PROD_W'(bfic_pkg::HASH_MUL);

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("front pushed into a full queue");

  a_accept_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |-> push_o)
    else $error("accepted word not pushed");

endmodule

// ===== design/bfic_queue.sv =====
// Short FIFO of decoded words between the front and back ends.
// Depends on bfic_pkg for the entry type and depth.
module bfic_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  bfic_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output bfic_pkg::item_t item_o
);

  bfic_pkg::item_t                    mem_q [bfic_pkg::QUEUE_DEPTH];
  logic [bfic_pkg::QPTR_W-1:0]        wr_ptr_q, rd_ptr_q;
  logic [bfic_pkg::QCNT_W-1:0]        count_q;

  function automatic logic [bfic_pkg::QPTR_W-1:0] ptr_inc(
    input logic [bfic_pkg::QPTR_W-1:0] p
  );
    return (p == bfic_pkg::QPTR_W'(bfic_pkg::QUEUE_DEPTH - 1)) ? '0
           : p + bfic_pkg::QPTR_W'(1);
  endfunction

  assign full_o  = (count_q == bfic_pkg::QCNT_W'(bfic_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + bfic_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - bfic_pkg::QCNT_W'(1);
      end
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("pop from empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bfic_pkg::QCNT_W'(bfic_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== design/bfic_back.sv =====
// Back end: remainder of 53*key by the bit count, probe walk over the bit
// store, and the result register. Depends on bfic_pkg; fed by bfic_queue.
module bfic_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bfic_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  bfic_pkg::item_t q_item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            present_o
);

  bfic_pkg::back_state_e              state_q, state_d;
  bfic_pkg::op_e                      op_q, op_d;
  logic [bfic_pkg::PROD_W-1:0]        prod_q, prod_d;
  logic [bfic_pkg::NB_W-1:0]          rem_q, rem_d;
  logic [bfic_pkg::NB_W-1:0]          c_q, c_d;
  logic [bfic_pkg::NB_W-1:0]          nbits_q, nbits_d;
  logic [bfic_pkg::K_W-1:0]           k_q, k_d;
  logic [bfic_pkg::K_W-1:0]           seed_q, seed_d;
  logic [bfic_pkg::DCNT_W-1:0]        div_cnt_q, div_cnt_d;
  logic                               hit_q, hit_d;
  logic                               out_valid_q, out_valid_d;
  logic                               present_q, present_d;
  logic [bfic_pkg::WORD_W-1:0]        store_q [bfic_pkg::STORE_WORDS];

  logic [bfic_pkg::NB_W-1:0]          div_mid, div_new;
  logic [bfic_pkg::NB_W-1:0]          p_sum, p_mod;
  logic [bfic_pkg::WIDX_W-1:0]        widx;
  logic [bfic_pkg::WORD_W-1:0]        mask;
  logic                               bit_set;
  logic                               clr, set_en;

  function automatic logic [bfic_pkg::NB_W-1:0] mod_step(
    input logic [bfic_pkg::NB_W-1:0] rem,
    input logic                      b,
    input logic [bfic_pkg::NB_W-1:0] n
  );
    logic [bfic_pkg::NB_W-1:0] t;
    t = {rem[bfic_pkg::NB_W-2:0], b};
    return (t >= n) ? t - n : t;
  endfunction

  function automatic logic [bfic_pkg::NB_W-1:0] seed_mod(
    input logic [bfic_pkg::NB_W-1:0] n
  );
    logic [bfic_pkg::NB_W-1:0]     r;
    logic [bfic_pkg::SEED_W-1:0]   s;
    r = '0;
    s = bfic_pkg::SEED_W'(bfic_pkg::SEED_MUL);
    for (int i = bfic_pkg::SEED_W - 1; i >= 0; i--) begin
      r = mod_step(r, s[i], n);
    end
    return r;
  endfunction

  assign div_mid = mod_step(rem_q, prod_q[bfic_pkg::PROD_W-1], nbits_q);
  assign div_new = mod_step(div_mid, prod_q[bfic_pkg::PROD_W-2], nbits_q);

  assign p_sum   = rem_q + c_q;
  assign p_mod   = (p_sum >= nbits_q) ? p_sum - nbits_q : p_sum;
  assign widx    = p_mod[bfic_pkg::POS_W-1:bfic_pkg::BIT_W];
  assign mask    = {1'b1, {(bfic_pkg::WORD_W-1){1'b0}}} >> p_mod[bfic_pkg::BIT_W-1:0];
  assign bit_set = |(store_q[widx] & mask);

  assign out_valid_o = out_valid_q;
  assign present_o   = present_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    c_d         = c_q;
    nbits_d     = nbits_q;
    k_d         = k_q;
    seed_d      = seed_q;
    div_cnt_d   = div_cnt_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    present_d   = present_q;
    pop_o       = 1'b0;
    clr         = 1'b0;
    set_en      = 1'b0;
    unique case (state_q)
      bfic_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          pop_o     = 1'b1;
          op_d      = q_item_i.op;
          prod_d    = q_item_i.prod;
          nbits_d   = cfg_i.nbits;
          k_d       = cfg_i.hashes;
          c_d       = seed_mod(cfg_i.nbits);
          rem_d     = '0;
          seed_d    = '0;
          div_cnt_d = bfic_pkg::DCNT_W'(bfic_pkg::DIV_STEPS - 1);
          hit_d     = 1'b1;
          state_d   = bfic_pkg::ST_DONE;
          unique case (q_item_i.op)
            bfic_pkg::OP_CLEAR: clr = 1'b1;
            bfic_pkg::OP_NOP:   hit_d = 1'b0;
            default: begin
              if (cfg_i.hashes != '0) begin
                state_d = bfic_pkg::ST_DIV;
              end
            end
          endcase
        end
      end
      bfic_pkg::ST_DIV: begin
        rem_d  = div_new;
        prod_d = prod_q << 2;
        if (div_cnt_q == '0) begin
          state_d = bfic_pkg::ST_PROBE;
        end else begin
          div_cnt_d = div_cnt_q - bfic_pkg::DCNT_W'(1);
        end
      end
      bfic_pkg::ST_PROBE: begin
        rem_d  = p_mod;
        seed_d = seed_q + bfic_pkg::K_W'(1);
        if (op_q == bfic_pkg::OP_INSERT) begin
          set_en = 1'b1;
        end else if (!bit_set) begin
          hit_d   = 1'b0;
          state_d = bfic_pkg::ST_DONE;
        end
        if (seed_d == k_q) begin
          state_d = bfic_pkg::ST_DONE;
        end
      end
      bfic_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          present_d   = hit_q;
          state_d     = bfic_pkg::ST_IDLE;
        end
      end
      default: state_d = bfic_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bfic_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    c_q       <= c_d;
    nbits_q   <= nbits_d;
    k_q       <= k_d;
    seed_q    <= seed_d;
    div_cnt_q <= div_cnt_d;
    hit_q     <= hit_d;
    present_q <= present_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < bfic_pkg::STORE_WORDS; i++) begin
        store_q[i] <= '0;
      end
    end else if (clr) begin
      for (int i = 0; i < bfic_pkg::STORE_WORDS; i++) begin
        store_q[i] <= '0;
      end
    end else if (set_en) begin
      store_q[widx] <= store_q[widx] | mask;
    end
  end

  a_probe_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfic_pkg::ST_PROBE |-> rem_q < nbits_q && c_q < nbits_q)
    else $error("probe position out of range");

  a_div_to_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfic_pkg::ST_DIV && div_cnt_q == '0) |=> state_q == bfic_pkg::ST_PROBE)
    else $error("remainder pass did not hand over to probing");

  a_insert_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfic_pkg::ST_PROBE && op_q == bfic_pkg::OP_INSERT)
      |=> (store_q[$past(widx)] & $past(mask)) != '0)
    else $error("insert probe left its bit clear");

  a_result_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfic_pkg::ST_DONE && (!out_valid_q || out_ready_i))
      |=> out_valid_q && present_q == $past(hit_q))
    else $error("result not loaded from probe outcome");

endmodule

// ===== design/bloom_filter_insert_check.sv =====
// Bloom filter block over a 1024-bit store: an insert or check word passes the
// back end as a fetch, a remainder pass reducing 53*key modulo the bit count two
// product bits per cycle, one probe per hash at one store word each and a result
// hand-off; a check stops at its first clear bit, and a clear, an unused command
// or k = 0 goes from the fetch straight to the hand-off. A two-word queue
// lets the front take new words while the back end is busy; the store is zero
// after reset. Depends on bfic_pkg, bfic_front, bfic_queue and bfic_back.
module bloom_filter_insert_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bfic_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [bfic_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bfic_pkg::CMD_W-1:0]        cmd_i,
  input  logic [bfic_pkg::KEY_W-1:0]        key_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              present_o
);

  logic [bfic_pkg::NUM_HASHES_W-1:0] num_hashes_q;
  logic [bfic_pkg::BIT_COUNT_W-1:0]  bit_count_q;
  bfic_pkg::cfg_t                    cfg;
  logic                              q_full, push, pop, q_valid;
  bfic_pkg::item_t                   push_item, q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_hashes_q <= bfic_pkg::NUM_HASHES_W'(2);
      bit_count_q  <= bfic_pkg::BIT_COUNT_W'(1024);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfic_pkg::CFG_NUM_HASHES: num_hashes_q <= cfg_data_i[bfic_pkg::NUM_HASHES_W-1:0];
        bfic_pkg::CFG_BIT_COUNT:  bit_count_q  <= cfg_data_i[bfic_pkg::BIT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.hashes = (num_hashes_q > bfic_pkg::MAX_HASHES)
               ? bfic_pkg::K_W'(bfic_pkg::MAX_HASHES)
               : bfic_pkg::K_W'(num_hashes_q);
    if (bit_count_q == '0) begin
      cfg.nbits = bfic_pkg::NB_W'(1);
    end else if (bit_count_q > bfic_pkg::MAX_BITS) begin
      cfg.nbits = bfic_pkg::NB_W'(bfic_pkg::MAX_BITS);
    end else begin
      cfg.nbits = bfic_pkg::NB_W'(bit_count_q);
    end
  end

  bfic_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .key_i      (key_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  bfic_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  bfic_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .present_o   (present_o)
  );

endmodule
